// ===== hw/rtl/rigid_body_force_torque_virial_assert.svh =====
// Assertion macros used by the top-level RTL file of the rigid-body accumulator.
`ifndef RIGID_BODY_FORCE_TORQUE_VIRIAL_ASSERT_SVH
`define RIGID_BODY_FORCE_TORQUE_VIRIAL_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RBFTV_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rbftv: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define RBFTV_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rbftv: next-cycle check failed");
`else
`define RBFTV_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RBFTV_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/rbftv_pkg.sv =====
package rbftv_pkg;

    localparam int IN_W     = 32;
    localparam int SUM_W    = 64;
    localparam int NUM_SUMS = 15;
    localparam int NUM_PROD = 9;
    localparam int COMP_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Layout of the sum vector.
    localparam int FORCE_BASE  = 0;
    localparam int TORQUE_BASE = 3;
    localparam int VIRIAL_BASE = 6;
    localparam logic [COMP_W-1:0] LAST_COMP = COMP_W'(NUM_SUMS - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_POS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_POS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_POS_Z = 2'd2;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic dir;
    } stage_ctrl_t;

    function automatic sum_t sat_add(input sum_t a, input sum_t b);
        logic signed [SUM_W:0] s;
        sum_t r;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = s[SUM_W-1:0];
        end
        return r;
    endfunction

    function automatic sum_t sat_sub(input sum_t a, input sum_t b);
        logic signed [SUM_W:0] s;
        sum_t r;
        s = {a[SUM_W-1], a} - {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = s[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/rbftv_front.sv =====
module rbftv_front import rbftv_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         s_valid,
    input  logic [IN_W-1:0]              force_in  [3],
    input  logic [IN_W-1:0]              pos_in    [3],
    input  logic [IN_W-1:0]              torque_in [3],
    input  logic                         dir_in,
    input  logic                         last_in,
    input  logic signed [WORD_WIDTH-1:0] body_pos  [3],
    output stage_ctrl_t                  st2_ctrl,
    output logic signed [WORD_WIDTH-1:0] force_out  [3],
    output logic signed [WORD_WIDTH-1:0] torque_out [3],
    output logic signed [2*WORD_WIDTH:0] prod_out   [NUM_PROD]
);

    localparam int PROD_W = 2 * WORD_WIDTH + 1;

    stage_ctrl_t                  st1_ctrl_reg;
    stage_ctrl_t                  st2_ctrl_reg;
    logic signed [WORD_WIDTH-1:0] f1_reg [3];
    logic signed [WORD_WIDTH-1:0] p1_reg [3];
    logic signed [WORD_WIDTH-1:0] t1_reg [3];
    logic signed [WORD_WIDTH-1:0] f2_reg [3];
    logic signed [WORD_WIDTH-1:0] t2_reg [3];
    logic signed [PROD_W-1:0]     prod_reg  [NUM_PROD];
    logic signed [WORD_WIDTH:0]   offset    [3];
    logic signed [PROD_W-1:0]     prod_next [NUM_PROD];

    // Offset from the body center is exact, one bit wider than a word.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            offset[i] = (WORD_WIDTH+1)'(p1_reg[i]) - (WORD_WIDTH+1)'(body_pos[i]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[3*i+j] = PROD_W'(offset[i]) * PROD_W'(f1_reg[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_ctrl_reg <= '0;
            st2_ctrl_reg <= '0;
        end else if (adv) begin
            st1_ctrl_reg <= '{valid: s_valid, last: last_in, dir: dir_in};
            st2_ctrl_reg <= st1_ctrl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s_valid) begin
            for (int i = 0; i < 3; i++) begin
                f1_reg[i] <= force_in[i][WORD_WIDTH-1:0];
                p1_reg[i] <= pos_in[i][WORD_WIDTH-1:0];
                t1_reg[i] <= torque_in[i][WORD_WIDTH-1:0];
            end
        end
        if (adv && st1_ctrl_reg.valid) begin
            f2_reg   <= f1_reg;
            t2_reg   <= t1_reg;
            prod_reg <= prod_next;
        end
    end

    assign st2_ctrl   = st2_ctrl_reg;
    assign force_out  = f2_reg;
    assign torque_out = t2_reg;
    assign prod_out   = prod_reg;

endmodule

// ===== hw/rtl/rbftv_accum.sv =====
module rbftv_accum import rbftv_pkg::*; #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  stage_ctrl_t                  ctrl,
    input  logic signed [WORD_WIDTH-1:0] force_in  [3],
    input  logic signed [WORD_WIDTH-1:0] torque_in [3],
    input  logic signed [2*WORD_WIDTH:0] prod_in   [NUM_PROD],
    output logic                         load,
    output sum_t                         sums_out  [NUM_SUMS]
);

    localparam int PROD_W = 2 * WORD_WIDTH + 1;
    localparam int RND_W  = PROD_W + 1;
    localparam logic signed [RND_W-1:0] HALF = RND_W'((RND_W'(1) << FRAC_BITS) >> 1);
    localparam int AIDX [3] = '{1, 2, 0};
    localparam int BIDX [3] = '{2, 0, 1};

    sum_t sums_reg  [NUM_SUMS];
    sum_t sums_next [NUM_SUMS];
    sum_t rnd       [NUM_PROD];

    // Round half up to FRAC_BITS fractional bits (floor after adding half an LSB).
    function automatic sum_t round_prod(input logic signed [PROD_W-1:0] p);
        logic signed [RND_W-1:0] s;
        s = RND_W'(p) + HALF;
        s = s >>> FRAC_BITS;
        return s[SUM_W-1:0];
    endfunction

    always_comb begin
        sum_t tq;
        for (int k = 0; k < NUM_PROD; k++) begin
            rnd[k] = round_prod(prod_in[k]);
        end
        for (int i = 0; i < 3; i++) begin
            sums_next[FORCE_BASE+i] = sat_add(sums_reg[FORCE_BASE+i], SUM_W'(force_in[i]));
        end
        // Torque terms are clamped one at a time.
        for (int i = 0; i < 3; i++) begin
            tq = sat_add(sums_reg[TORQUE_BASE+i], rnd[3*AIDX[i]+BIDX[i]]);
            tq = sat_sub(tq, rnd[3*BIDX[i]+AIDX[i]]);
            if (ctrl.dir) begin
                tq = sat_add(tq, SUM_W'(torque_in[i]));
            end
            sums_next[TORQUE_BASE+i] = tq;
        end
        for (int k = 0; k < NUM_PROD; k++) begin
            sums_next[VIRIAL_BASE+k] = sat_sub(sums_reg[VIRIAL_BASE+k], rnd[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_reg <= '{default: '0};
        end else if (adv && ctrl.valid) begin
            if (ctrl.last) begin
                sums_reg <= '{default: '0};
            end else begin
                sums_reg <= sums_next;
            end
        end
    end

    assign load     = adv && ctrl.valid && ctrl.last;
    assign sums_out = sums_next;

endmodule

// ===== hw/rtl/rbftv_drain.sv =====
module rbftv_drain import rbftv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  sum_t              sums_in [NUM_SUMS],
    input  logic              m_ready,
    output logic              m_valid,
    output logic [COMP_W-1:0] m_component,
    output sum_t              m_sum_value,
    output logic              m_last_word
);

    sum_t              bank_reg [NUM_SUMS];
    logic [COMP_W-1:0] idx_reg;
    logic              busy_reg;
    logic              take;

    assign take = busy_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (take) begin
            if (idx_reg == LAST_COMP) begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // The bank shifts toward entry zero as words are taken.
    always_ff @(posedge aclk) begin
        if (load) begin
            bank_reg <= sums_in;
        end else if (take) begin
            for (int k = 0; k < NUM_SUMS - 1; k++) begin
                bank_reg[k] <= bank_reg[k+1];
            end
        end
    end

    assign m_valid     = busy_reg;
    assign m_component = idx_reg;
    assign m_sum_value = bank_reg[0];
    assign m_last_word = (idx_reg == LAST_COMP);

endmodule

// ===== hw/rtl/rigid_body_force_torque_virial.sv =====
// A last atom passes stage one, then stage two; then its sums load the output bank and m_valid rises.
// Throughput: one atom per cycle unless stalled; 15 words per run leave at one per cycle with m_ready high.
// A last atom waits in the accumulate stage only while the previous run is still draining.
// Reset (aresetn, synchronous, active low) clears the sums, the body position and all
// pipeline and output control state.
`include "rigid_body_force_torque_virial_assert.svh"

module rigid_body_force_torque_virial import rbftv_pkg::*; #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [IN_W-1:0]        cfg_data,

    // Atom input channel.
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [IN_W-1:0] s_force_x,
    input  logic signed [IN_W-1:0] s_force_y,
    input  logic signed [IN_W-1:0] s_force_z,
    input  logic signed [IN_W-1:0] s_atom_pos_x,
    input  logic signed [IN_W-1:0] s_atom_pos_y,
    input  logic signed [IN_W-1:0] s_atom_pos_z,
    input  logic signed [IN_W-1:0] s_atom_torque_x,
    input  logic signed [IN_W-1:0] s_atom_torque_y,
    input  logic signed [IN_W-1:0] s_atom_torque_z,
    input  logic                   s_is_directional,
    input  logic                   s_last_atom,

    // Result channel.
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COMP_W-1:0]      m_component,
    output sum_t                   m_sum_value,
    output logic                   m_last_word
);

    logic signed [WORD_WIDTH-1:0] body_pos_reg [3];
    logic [IN_W-1:0]              force_in  [3];
    logic [IN_W-1:0]              pos_in    [3];
    logic [IN_W-1:0]              torque_in [3];
    stage_ctrl_t                  st2_ctrl;
    logic signed [WORD_WIDTH-1:0] st2_force  [3];
    logic signed [WORD_WIDTH-1:0] st2_torque [3];
    logic signed [2*WORD_WIDTH:0] st2_prod   [NUM_PROD];
    logic                         adv;
    logic                         acc_load;
    sum_t                         acc_sums [NUM_SUMS];

    // The configuration port never stalls. Writes to an index outside the
    // register list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_pos_reg <= '{default: '0};
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BODY_POS_X: body_pos_reg[0] <= cfg_data[WORD_WIDTH-1:0];
                CFG_BODY_POS_Y: body_pos_reg[1] <= cfg_data[WORD_WIDTH-1:0];
                CFG_BODY_POS_Z: body_pos_reg[2] <= cfg_data[WORD_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign force_in  = '{s_force_x, s_force_y, s_force_z};
    assign pos_in    = '{s_atom_pos_x, s_atom_pos_y, s_atom_pos_z};
    assign torque_in = '{s_atom_torque_x, s_atom_torque_y, s_atom_torque_z};

    // The whole pipeline advances together. It holds only when a last atom
    // sits in the accumulate stage while the output bank still drains the
    // previous run; the drain state is registered, so ready never depends
    // combinationally on m_ready.
    assign adv     = !(st2_ctrl.valid && st2_ctrl.last && m_valid);
    assign s_ready = adv;

    // Stage one registers the atom; stage two holds the offset-times-force products.
    rbftv_front #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .s_valid    (s_valid),
        .force_in   (force_in),
        .pos_in     (pos_in),
        .torque_in  (torque_in),
        .dir_in     (s_is_directional),
        .last_in    (s_last_atom),
        .body_pos   (body_pos_reg),
        .st2_ctrl   (st2_ctrl),
        .force_out  (st2_force),
        .torque_out (st2_torque),
        .prod_out   (st2_prod)
    );

    // Rounding and saturating accumulation of the fifteen sums. On the last
    // atom the updated sums move to the output bank and the sums clear.
    rbftv_accum #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .ctrl      (st2_ctrl),
        .force_in  (st2_force),
        .torque_in (st2_torque),
        .prod_in   (st2_prod),
        .load      (acc_load),
        .sums_out  (acc_sums)
    );

    // Output bank: force, torque, then virial row-major, one word per transaction.
    rbftv_drain u_drain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (acc_load),
        .sums_in     (acc_sums),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_component (m_component),
        .m_sum_value (m_sum_value),
        .m_last_word (m_last_word)
    );

    // The input stalls only because a previous run is still draining.
    `RBFTV_ASSERT_IMP(a_stall_needs_drain, aclk, aresetn, !s_ready, m_valid)
    // A new run is loaded only into an empty output bank.
    `RBFTV_ASSERT_IMP(a_load_when_idle, aclk, aresetn, acc_load, !m_valid)
    // Components of a run leave in ascending order without gaps.
    `RBFTV_ASSERT_NXT(a_comp_step, aclk, aresetn, m_valid && m_ready && !m_last_word,
        m_valid && (m_component == COMP_W'($past(m_component) + 1'b1)))
    // In the cycle after the last word of a run is taken, the bank is empty.
    `RBFTV_ASSERT_NXT(a_run_ends, aclk, aresetn, m_valid && m_ready && m_last_word, !m_valid)

endmodule
